### hw/rtl/zero_crossing_edge_map_defines.svh
// ----------------------------------------------------------------------------
// Zero-crossing edge map assertion macros
// Shared concurrent assertion helpers; defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_EDGE_MAP_DEFINES_SVH
`define ZERO_CROSSING_EDGE_MAP_DEFINES_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ZCEM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define ZCEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ZCEM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ZCEM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/zcem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing edge map package
// Field widths, register defaults, sign classes and shared helper functions.
// ----------------------------------------------------------------------------
package zcem_pkg;

   localparam int DEF_MAX_COLS = 1024;
   localparam int DEF_MAX_ROWS = 4096;
   localparam int MIN_SIZE     = 3;

   localparam int SAMPLE_W    = 16;
   localparam int OUT_ROW_W   = 12;
   localparam int OUT_COL_W   = 10;
   localparam int ROWS_REG_W  = 13;
   localparam int COLS_REG_W  = 11;
   localparam int MARGIN_W    = 6;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   localparam logic [ROWS_REG_W-1:0] ROWS_RESET   = ROWS_REG_W'(480);
   localparam logic [COLS_REG_W-1:0] COLS_RESET   = COLS_REG_W'(640);
   localparam logic [MARGIN_W-1:0]   MARGIN_RESET = MARGIN_W'(3);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_ROWS,
      CSR_IMAGE_COLS,
      CSR_MARGIN
   } csr_index_type;

   typedef logic [1:0] sign_type;

   localparam sign_type SIGN_ZERO = 2'd0;
   localparam sign_type SIGN_POS  = 2'd1;
   localparam sign_type SIGN_NEG  = 2'd2;

   // Sign classes of the two previous rows at one column.
   typedef struct packed {
      sign_type upper;
      sign_type middle;
   } line_entry_type;

   function automatic sign_type sign_class(logic signed [SAMPLE_W-1:0] value);
      sign_type cls;
      if (value == '0) begin
         cls = SIGN_ZERO;
      end else if (value[SAMPLE_W-1]) begin
         cls = SIGN_NEG;
      end else begin
         cls = SIGN_POS;
      end
      return cls;
   endfunction

   // A pair crosses zero only when one side is positive and the other negative.
   function automatic logic opposite(sign_type a, sign_type b);
      return (a | b) == (SIGN_POS | SIGN_NEG);
   endfunction

endpackage

### hw/rtl/zcem_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing edge map request channel
// Valid/ready channel carrying one Laplacian sample and a start-of-frame flag.
// ----------------------------------------------------------------------------
interface zcem_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [zcem_pkg::SAMPLE_W-1:0]  sample;
   logic                                  start_of_frame;

   modport source (output valid, output sample, output start_of_frame, input ready);
   modport sink   (input valid, input sample, input start_of_frame, output ready);
endinterface

### hw/rtl/zcem_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing edge map response channel
// Valid/ready channel carrying the position and edge decision of one pixel.
// ----------------------------------------------------------------------------
interface zcem_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [zcem_pkg::OUT_ROW_W-1:0]  out_row;
   logic [zcem_pkg::OUT_COL_W-1:0]  out_col;
   logic                            edge_res;

   modport source (output valid, output out_row, output out_col, output edge_res,
                   input ready);
   modport sink   (input valid, input out_row, input out_col, input edge_res,
                   output ready);
endinterface

### hw/rtl/zero_crossing_edge_map.sv
`timescale 1ns / 1ps
`include "zero_crossing_edge_map_defines.svh"
// ----------------------------------------------------------------------------
// Zero-crossing edge map
// Marr-Hildreth zero-crossing stage: sign classes of a LoG stream go through
// two line buffers and a 3x3 window; each pixel is marked where an opposite
// neighbor pair changes sign strictly, with the image border cleared.
// ----------------------------------------------------------------------------
//  channel | direction | handshake   | payload
//  req     | in        | valid/ready | sample, start_of_frame
//  rsp     | out       | valid/ready | out_row, out_col, edge_res
//  csr     | in        | csr_we      | csr_index, csr_wdata
//
//  One transaction per clock is sustained while rsp is not stalled; a result
//  moves from stage one (registered line buffer read) to the output register.
//  Reset clears the counters, the window and the pipeline valids; the line
//  buffer is not cleared and needs no sweep.
//  A stalled rsp holds the output register; req drops ready only while a
//  stalled result waits there and stage one holds a transaction that makes
//  another result.
// ----------------------------------------------------------------------------
module zero_crossing_edge_map #(
   parameter int MAX_COLS = zcem_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = zcem_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   zcem_req_if.sink                         req,
   zcem_rsp_if.source                       rsp,
   input  logic                             csr_we,
   input  logic [zcem_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [zcem_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import zcem_pkg::*;

   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COLS_W    = $clog2(MAX_COLS + 1);
   localparam int ROWS_W    = $clog2(MAX_ROWS + 1);
   localparam int COL_SUM_W = $clog2(MAX_COLS + 66);
   localparam int ROW_SUM_W = $clog2(MAX_ROWS + 66);

   // Configuration registers.
   logic [ROWS_REG_W-1:0] image_rows_ff;
   logic [COLS_REG_W-1:0] image_cols_ff;
   logic [MARGIN_W-1:0]   margin_ff;
   logic [ROWS_W-1:0]     rows_eff;
   logic [COLS_W-1:0]     cols_eff;

   // Position counters and the accept-side view of the current position.
   logic [ROW_W-1:0]      row_count_ff, row_count_in;
   logic [COL_W-1:0]      col_count_ff, col_count_in;
   logic [ROW_W-1:0]      pos_r;
   logic [COL_W-1:0]      pos_c;
   logic                  req_acc;

   // Stage one: the accepted sample waiting for its line buffer data.
   logic                  s1_valid_ff, s1_valid_in;
   logic [ROW_W-1:0]      s1_r_ff;
   logic [COL_W-1:0]      s1_c_ff;
   sign_type              s1_cls_ff;
   logic                  s1_emit;
   logic                  s1_go;

   // Line buffer with one-entry forwarding around the read/write overlap.
   line_entry_type        line_mem [MAX_COLS];
   line_entry_type        rd_ff;
   line_entry_type        fwd_data_ff;
   logic                  fwd_ff;
   line_entry_type        s1_line;
   line_entry_type        wr_entry;

   // 3x3 window of sign classes, [row][column], column 2 is the newest.
   sign_type              win_ff [3][3];

   // Decision logic.
   logic [ROW_SUM_W-1:0]  i_ext;
   logic [ROW_SUM_W-1:0]  m_r;
   logic [COL_SUM_W-1:0]  j_ext;
   logic [COL_SUM_W-1:0]  m_c;
   logic                  border;
   logic                  crossing;

   // Output register.
   logic                  o_valid_ff, o_valid_in;
   logic [OUT_ROW_W-1:0]  o_row_ff;
   logic [OUT_COL_W-1:0]  o_col_ff;
   logic                  o_edge_ff;

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff <= ROWS_RESET;
         image_cols_ff <= COLS_RESET;
         margin_ff     <= MARGIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_ROWS: image_rows_ff <= csr_wdata[ROWS_REG_W-1:0];
            CSR_IMAGE_COLS: image_cols_ff <= csr_wdata[COLS_REG_W-1:0];
            CSR_MARGIN:     margin_ff     <= csr_wdata[MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (image_rows_ff < ROWS_REG_W'(MIN_SIZE)) begin
         rows_eff = ROWS_W'(MIN_SIZE);
      end else if (32'(image_rows_ff) > 32'(MAX_ROWS)) begin
         rows_eff = ROWS_W'(MAX_ROWS);
      end else begin
         rows_eff = ROWS_W'(image_rows_ff);
      end
      if (image_cols_ff < COLS_REG_W'(MIN_SIZE)) begin
         cols_eff = COLS_W'(MIN_SIZE);
      end else if (32'(image_cols_ff) > 32'(MAX_COLS)) begin
         cols_eff = COLS_W'(MAX_COLS);
      end else begin
         cols_eff = COLS_W'(image_cols_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Accept side: position of the incoming sample
   // ------------------------------------------------------------------------
   assign req_acc = req.valid && req.ready;
   assign pos_r   = req.start_of_frame ? '0 : row_count_ff;
   assign pos_c   = req.start_of_frame ? '0 : col_count_ff;

   always_comb begin
      if (COLS_W'(pos_c) + COLS_W'(1) >= cols_eff) begin
         col_count_in = '0;
         if (ROWS_W'(pos_r) + ROWS_W'(1) >= rows_eff) begin
            row_count_in = '0;
         end else begin
            row_count_in = pos_r + ROW_W'(1);
         end
      end else begin
         col_count_in = pos_c + COL_W'(1);
         row_count_in = pos_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else if (req_acc) begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage one
   // ------------------------------------------------------------------------
   assign s1_emit     = (s1_r_ff != '0) && (s1_c_ff != '0);
   assign s1_go       = s1_valid_ff && (!s1_emit || !o_valid_ff || rsp.ready);
   assign req.ready   = !s1_valid_ff || s1_go;
   assign s1_valid_in = req_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_r_ff   <= pos_r;
         s1_c_ff   <= pos_c;
         s1_cls_ff <= sign_class(req.sample);
      end
   end

   // The column shifts down one row: old middle becomes upper, the new
   // sample becomes middle.
   assign s1_line  = fwd_ff ? fwd_data_ff : rd_ff;
   assign wr_entry = '{upper: s1_line.middle, middle: s1_cls_ff};

   always_ff @(posedge clock) begin
      if (s1_go) begin
         line_mem[s1_c_ff] <= wr_entry;
      end
      if (req_acc) begin
         rd_ff <= line_mem[pos_c];
      end
   end

   // A request accepted on the edge that retires one at the same column
   // must see the entry being written, not the stale memory word.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         fwd_ff      <= s1_go && (s1_c_ff == pos_c);
         fwd_data_ff <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
               win_ff[k][m] <= SIGN_ZERO;
            end
         end
      end else if (s1_go) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= s1_line.upper;
         win_ff[1][2] <= s1_line.middle;
         win_ff[2][2] <= s1_cls_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Decision for pixel (r-1, c-1) on the window as it will be after the shift
   // ------------------------------------------------------------------------
   assign crossing = opposite(win_ff[0][2], win_ff[2][2])   ||
                     opposite(win_ff[1][1], s1_line.middle) ||
                     opposite(win_ff[2][1], s1_line.upper)  ||
                     opposite(win_ff[0][1], s1_cls_ff);

   assign i_ext = ROW_SUM_W'(s1_r_ff) - ROW_SUM_W'(1);
   assign j_ext = COL_SUM_W'(s1_c_ff) - COL_SUM_W'(1);
   assign m_r   = ROW_SUM_W'(margin_ff);
   assign m_c   = COL_SUM_W'(margin_ff);

   assign border = (i_ext <= m_r) ||
                   (i_ext + m_r + ROW_SUM_W'(1) >= ROW_SUM_W'(rows_eff)) ||
                   (j_ext <= m_c) ||
                   (j_ext + m_c + COL_SUM_W'(1) >= COL_SUM_W'(cols_eff));

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   always_comb begin
      if (s1_go && s1_emit) begin
         o_valid_in = 1'b1;
      end else if (rsp.ready) begin
         o_valid_in = 1'b0;
      end else begin
         o_valid_in = o_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit) begin
         o_row_ff  <= OUT_ROW_W'(i_ext);
         o_col_ff  <= OUT_COL_W'(j_ext);
         o_edge_ff <= crossing && !border;
      end
   end

   assign rsp.valid    = o_valid_ff;
   assign rsp.out_row  = o_row_ff;
   assign rsp.out_col  = o_col_ff;
   assign rsp.edge_res = o_edge_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `ZCEM_ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, !req.ready, s1_valid_ff && o_valid_ff)
   `ZCEM_ASSERT_NEXT(a_emit_fills_output, clock, reset, s1_go && s1_emit, o_valid_ff)
   `ZCEM_ASSERT_NEXT(a_frame_start_at_origin, clock, reset, req_acc && req.start_of_frame, (s1_r_ff == '0) && (s1_c_ff == '0))
   `ZCEM_ASSERT_IMPLIES(a_output_from_stage, clock, reset, $rose(o_valid_ff), $past(s1_valid_ff))

endmodule

### tb/zcem_edge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing edge map checker
// Watches the request, response and register ports of the edge map. It keeps
// its own copy of the sign window, line buffers, position counters and size
// registers, predicts each pixel decision, and compares every response
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module zcem_edge_checker #(
   parameter int MAX_COLS = zcem_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = zcem_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   zcem_req_if                              req,
   zcem_rsp_if                              rsp,
   input  logic                             csr_we,
   input  logic [zcem_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [zcem_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               fail_count,
   output int                               pending_count,
   output int                               decision_count,
   output int                               edge_count
);
   import zcem_pkg::*;

   localparam int REPORT_LIMIT = 100;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic                 is_edge;
   } decision_type;

   decision_type pending_decisions[$];
   decision_type oldest;

   sign_type upper_line  [MAX_COLS];
   sign_type middle_line [MAX_COLS];
   sign_type window      [3][3];

   logic [ROWS_REG_W-1:0] rows_reg;
   logic [COLS_REG_W-1:0] cols_reg;
   logic [MARGIN_W-1:0]   margin_reg;
   int unsigned           next_row;
   int unsigned           next_col;
   int                    report_count;

   function automatic int unsigned clamp_size(int unsigned value, int unsigned limit);
      int unsigned fitted;
      fitted = value;
      if (fitted < MIN_SIZE) begin
         fitted = MIN_SIZE;
      end else if (fitted > limit) begin
         fitted = limit;
      end
      return fitted;
   endfunction

   function automatic logic crosses(sign_type a, sign_type b);
      return (a == SIGN_POS && b == SIGN_NEG) || (a == SIGN_NEG && b == SIGN_POS);
   endfunction

   // Counts a failure and tells whether it may still be printed.
   function automatic bit log_failure();
      fail_count++;
      report_count++;
      if (report_count == REPORT_LIMIT + 1) begin
         $display("Further mismatches are counted but not printed.");
      end
      return report_count <= REPORT_LIMIT;
   endfunction

   task automatic decide_pixel(input logic [SAMPLE_W-1:0] sample, input logic sof);
      int unsigned  rows;
      int unsigned  cols;
      int unsigned  r;
      int unsigned  c;
      int unsigned  i;
      int unsigned  j;
      sign_type     cls;
      logic         border;
      decision_type decision;
      rows = clamp_size(int'(rows_reg), MAX_ROWS);
      cols = clamp_size(int'(cols_reg), MAX_COLS);
      if (sof) begin
         next_row = 0;
         next_col = 0;
      end
      r = next_row;
      c = next_col % MAX_COLS;

      if (sample == '0) begin
         cls = SIGN_ZERO;
      end else if (sample[SAMPLE_W-1]) begin
         cls = SIGN_NEG;
      end else begin
         cls = SIGN_POS;
      end

      for (int k = 0; k < 3; k++) begin
         window[k][0] = window[k][1];
         window[k][1] = window[k][2];
      end
      window[0][2]   = upper_line[c];
      window[1][2]   = middle_line[c];
      window[2][2]   = cls;
      upper_line[c]  = middle_line[c];
      middle_line[c] = cls;

      // The centre of the window is one row up and one column left.
      if (r >= 1 && c >= 1) begin
         i = r - 1;
         j = c - 1;
         border = (i <= margin_reg) || (i + margin_reg + 1 >= rows) ||
                  (j <= margin_reg) || (j + margin_reg + 1 >= cols);
         decision.row     = OUT_ROW_W'(i);
         decision.col     = OUT_COL_W'(j);
         decision.is_edge = !border &&
                            (crosses(window[0][1], window[2][1]) ||
                             crosses(window[1][0], window[1][2]) ||
                             crosses(window[2][0], window[0][2]) ||
                             crosses(window[0][0], window[2][2]));
         pending_decisions.push_back(decision);
      end

      if (c + 1 >= cols) begin
         next_col = 0;
         next_row = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rows_reg   = ROWS_RESET;
         cols_reg   = COLS_RESET;
         margin_reg = MARGIN_RESET;
         next_row   = 0;
         next_col   = 0;
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
               window[k][m] = SIGN_ZERO;
            end
         end
         for (int n = 0; n < MAX_COLS; n++) begin
            upper_line[n]  = SIGN_ZERO;
            middle_line[n] = SIGN_ZERO;
         end
         pending_decisions.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_ROWS: rows_reg   = csr_wdata[ROWS_REG_W-1:0];
               CSR_IMAGE_COLS: cols_reg   = csr_wdata[COLS_REG_W-1:0];
               CSR_MARGIN:     margin_reg = csr_wdata[MARGIN_W-1:0];
               default: ;
            endcase
         end

         if (req.valid && req.ready) begin
            decide_pixel(req.sample, req.start_of_frame);
         end

         if (rsp.valid && rsp.ready) begin
            if (pending_decisions.size() == 0) begin
               if (log_failure()) begin
                  $error("Unexpected result: out_row %0d, out_col %0d, edge_res %0d",
                         rsp.out_row, rsp.out_col, rsp.edge_res);
               end
            end else begin
               oldest = pending_decisions.pop_front();
               decision_count++;
               if (oldest.is_edge) begin
                  edge_count++;
               end
               if (rsp.out_row !== oldest.row) begin
                  if (log_failure()) begin
                     $error("out_row mismatch: expected %0d, actual %0d",
                            oldest.row, rsp.out_row);
                  end
               end
               if (rsp.out_col !== oldest.col) begin
                  if (log_failure()) begin
                     $error("out_col mismatch: expected %0d, actual %0d",
                            oldest.col, rsp.out_col);
                  end
               end
               if (rsp.edge_res !== oldest.is_edge) begin
                  if (log_failure()) begin
                     $error("edge_res mismatch: expected %0d, actual %0d",
                            oldest.is_edge, rsp.edge_res);
                  end
               end
            end
         end
      end
      pending_count = pending_decisions.size();
   end

endmodule

### tb/tb_zero_crossing_edge_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing edge map testbench
// Streams Laplacian samples into the edge map with random gaps on both
// channels: a few hand-built images with each crossing direction, then a
// gap-free image as wide as any random size, then random image sizes with
// restarts, truncated images and size changes. A checker beside the block
// predicts and compares every pixel decision.
// ----------------------------------------------------------------------------
module tb_zero_crossing_edge_map;
   import zcem_pkg::*;

   localparam int RANDOM_ITEMS  = 1050;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRIME_ROWS    = 4;
   localparam int PRIME_COLS    = 40;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   steady_flow = 1'b0;

   int fail_count;
   int pending_count;
   int decision_count;
   int edge_count;
   int items_sent;
   int settings_used;
   int random_items;

   // Three rows by four columns: an anti-diagonal and a diagonal crossing.
   logic [SAMPLE_W-1:0] diagonal_image [12] = '{
      16'h0000, 16'h7FFF, 16'h8000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0001, 16'h0000, 16'h0000, 16'hFFFF
   };
   // Same size: a vertical and a horizontal crossing.
   logic [SAMPLE_W-1:0] straight_image [12] = '{
      16'h0000, 16'h7FFF, 16'h0000, 16'h0000,
      16'h0000, 16'hFFFF, 16'h0000, 16'h0001,
      16'h0000, 16'h8000, 16'h0000, 16'h0000
   };

   zcem_req_if req_bus ();
   zcem_rsp_if rsp_bus ();

   zero_crossing_edge_map u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   zcem_edge_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .decision_count (decision_count),
      .edge_count     (edge_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Response side back-pressure.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 30);
      end
   end

   function automatic int fit_size(int value, int limit);
      int fitted;
      fitted = value;
      if (fitted < MIN_SIZE) begin
         fitted = MIN_SIZE;
      end else if (fitted > limit) begin
         fitted = limit;
      end
      return fitted;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] value;
      case ($urandom_range(0, 9))
         0, 1, 2: value = '0;
         3: begin
            case ($urandom_range(0, 3))
               0:       value = 16'h7FFF;
               1:       value = 16'h8000;
               2:       value = 16'h0001;
               default: value = 16'hFFFF;
            endcase
         end
         default: value = SAMPLE_W'($urandom);
      endcase
      return value;
   endfunction

   function automatic int pick_rows();
      int value;
      case ($urandom_range(0, 9))
         0:       value = $urandom_range(0, 2);
         1:       value = $urandom_range(11, 24);
         default: value = $urandom_range(3, 10);
      endcase
      return value;
   endfunction

   function automatic int pick_cols();
      int value;
      case ($urandom_range(0, 9))
         0:       value = $urandom_range(0, 2);
         1:       value = $urandom_range(13, PRIME_COLS);
         default: value = $urandom_range(3, 12);
      endcase
      return value;
   endfunction

   function automatic int pick_margin();
      int value;
      case ($urandom_range(0, 9))
         0:          value = $urandom_range(5, 63);
         1, 2, 3:    value = $urandom_range(2, 4);
         default:    value = $urandom_range(0, 1);
      endcase
      return value;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input logic [SAMPLE_W-1:0] sample, input logic sof);
      while (!steady_flow && $urandom_range(0, 99) < 30) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.sample         <= sample;
      req_bus.start_of_frame <= sof;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Row-0 samples give no result, so the block may still be busy when the
   // last decision has come out; a settle wait then covers its pipeline.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_sizes(input int rows, input int cols, input int margin);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_ROWS;
      csr_wdata <= CSR_DATA_W'(rows);
      @(negedge clock);
      csr_index <= CSR_IMAGE_COLS;
      csr_wdata <= CSR_DATA_W'(cols);
      @(negedge clock);
      csr_index <= CSR_MARGIN;
      csr_wdata <= CSR_DATA_W'(margin);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic write_register(input csr_index_type index, input int value);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int   rows;
      int   cols;
      int   margin;
      int   eff_rows;
      int   eff_cols;
      int   length;
      int   frames;
      logic sof;

      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.sample         <= '0;
      req_bus.start_of_frame <= 1'b0;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_IMAGE_ROWS;
      csr_wdata              <= '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset sizes: a first-row sample yields no decision.
      send_item(16'h7FFF, 1'b1);

      // Row count below the minimum is raised to three.
      program_sizes(1, 4, 0);
      for (int n = 0; n < 12; n++) begin
         send_item(diagonal_image[n], n == 0);
      end
      // No start mark: the counters wrap into the next image.
      for (int n = 0; n < 12; n++) begin
         send_item(straight_image[n], 1'b0);
      end

      // Image as wide as any random size, run without gaps. It writes both
      // rows of every line buffer entry that later size changes can reach.
      program_sizes(PRIME_ROWS, PRIME_COLS, 0);
      steady_flow <= 1'b1;
      for (int n = 0; n < PRIME_ROWS * PRIME_COLS; n++) begin
         send_item(pick_sample(), n == 0);
      end
      steady_flow <= 1'b0;

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         rows   = pick_rows();
         cols   = pick_cols();
         margin = pick_margin();
         program_sizes(rows, cols, margin);
         eff_rows = fit_size(rows, DEF_MAX_ROWS);
         eff_cols = fit_size(cols, DEF_MAX_COLS);
         frames   = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            length = eff_rows * eff_cols;
            if ($urandom_range(0, 9) == 0) begin
               length = $urandom_range(1, length);
            end
            for (int n = 0; n < length; n++) begin
               sof = (n == 0) && (f == 0 || $urandom_range(0, 2) != 0);
               if ($urandom_range(0, 199) == 0) begin
                  sof = 1'b1;
               end
               send_item(pick_sample(), sof);
               random_items++;
            end
            if ($urandom_range(0, 4) == 0) begin
               wait_for_results();
            end
         end

         // Resize in the middle of an image and keep streaming.
         if ($urandom_range(0, 3) == 0) begin
            length = $urandom_range(1, eff_rows * eff_cols);
            for (int n = 0; n < length; n++) begin
               send_item(pick_sample(), n == 0);
               random_items++;
            end
            if ($urandom_range(0, 1) == 0) begin
               cols = pick_cols();
               write_register(CSR_IMAGE_COLS, cols);
               eff_cols = fit_size(cols, DEF_MAX_COLS);
            end else begin
               rows = pick_rows();
               write_register(CSR_IMAGE_ROWS, rows);
               eff_rows = fit_size(rows, DEF_MAX_ROWS);
            end
            length = 2 * eff_rows * eff_cols;
            for (int n = 0; n < length; n++) begin
               send_item(pick_sample(), 1'b0);
               random_items++;
            end
         end
      end

      wait_for_results();

      $display("Streamed %0d samples over %0d size settings, clamped 3x3 images up to",
               items_sent, settings_used);
      $display("24x40 with margins up to 63; %0d decisions checked, %0d edges.",
               decision_count, edge_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
